[src/sfn_pkg.sv]
// Shared constants and types for the spline fit normal equation accumulator.
// No dependencies.
package sfn_pkg;

   localparam int MAX_KNOTS_DEF = 32;
   localparam int MAX_ORDER_DEF = 5;

   localparam logic [2:0] OP_LOAD   = 3'd0;
   localparam logic [2:0] OP_ADD    = 3'd1;
   localparam logic [2:0] OP_RD_SUM = 3'd2;
   localparam logic [2:0] OP_RD_OFF = 3'd3;
   localparam logic [2:0] OP_CLEAR  = 3'd4;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_SAT   = 2'd2;

   localparam logic [1:0] CSR_KNOTS  = 2'd0;
   localparam logic [1:0] CSR_ORDER  = 2'd1;
   localparam logic [1:0] CSR_WEIGHT = 2'd2;

   localparam logic signed [63:0] Q32_ONE = 64'sh0000_0001_0000_0000;
   localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

   typedef struct packed {
      logic done;
      logic sat;
   } mul_rsp_type;

endpackage

[src/sfn_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module sfn_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[src/sfn_mul.sv]
// Multi-cycle signed 64x64 multiply, floor shift right by 16, saturated to 64 bits.
// Uses sfn_pkg for the response struct and saturation limits.
module sfn_mul (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [63:0]  op_a,
   input  logic signed [63:0]  op_b,
   output logic signed [63:0]  result,
   output sfn_pkg::mul_rsp_type rsp
);
   import sfn_pkg::*;

   typedef enum logic [2:0] {
      U_IDLE = 3'b001,
      U_RUN  = 3'b010,
      U_FIN  = 3'b100
   } ustate_type;

   ustate_type state_ff, state_in;
   logic [63:0]  ua_ff, ua_in, ub_ff, ub_in;
   logic         neg_ff, neg_in;
   logic [2:0]   cnt_ff, cnt_in;
   logic [63:0]  pp_ff, pp_in;
   logic [1:0]   sh_ff, sh_in;
   logic [127:0] acc_ff, acc_in;
   logic signed [63:0] res_ff, res_in;
   logic         done_ff, done_in, sat_ff, sat_in;
   logic [31:0]  ah, bh;
   logic [127:0] pp_shifted, prod;
   logic [48:0]  hi;

   always_comb begin
      ah = cnt_ff[1] ? ua_ff[63:32] : ua_ff[31:0];
      bh = cnt_ff[0] ? ub_ff[63:32] : ub_ff[31:0];
      case (sh_ff)
         2'd0:    pp_shifted = {64'd0, pp_ff};
         2'd1:    pp_shifted = {32'd0, pp_ff, 32'd0};
         default: pp_shifted = {pp_ff, 64'd0};
      endcase
      prod = neg_ff ? (128'd0 - acc_ff) : acc_ff;
      hi   = prod[127:79];

      state_in = state_ff;
      ua_in    = ua_ff;
      ub_in    = ub_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      pp_in    = pp_ff;
      sh_in    = sh_ff;
      acc_in   = acc_ff;
      res_in   = res_ff;
      done_in  = 1'b0;
      sat_in   = sat_ff;

      case (state_ff)
         U_IDLE: begin
            if (start) begin
               ua_in    = op_a[63] ? (64'd0 - op_a) : op_a;
               ub_in    = op_b[63] ? (64'd0 - op_b) : op_b;
               neg_in   = op_a[63] ^ op_b[63];
               cnt_in   = 3'd0;
               acc_in   = 128'd0;
               state_in = U_RUN;
            end
         end
         U_RUN: begin
            if (cnt_ff != 3'd4) begin
               pp_in = 64'(ah) * 64'(bh);
               sh_in = {1'b0, cnt_ff[0]} + {1'b0, cnt_ff[1]};
            end
            if (cnt_ff != 3'd0) begin
               acc_in = acc_ff + pp_shifted;
            end
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd4) begin
               state_in = U_FIN;
            end
         end
         U_FIN: begin
            if ((&hi) || !(|hi)) begin
               res_in = prod[79:16];
               sat_in = 1'b0;
            end else begin
               res_in = prod[127] ? S64_MIN : S64_MAX;
               sat_in = 1'b1;
            end
            done_in  = 1'b1;
            state_in = U_IDLE;
         end
         default: state_in = U_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      ua_ff  <= ua_in;
      ub_ff  <= ub_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      pp_ff  <= pp_in;
      sh_ff  <= sh_in;
      acc_ff <= acc_in;
      res_ff <= res_in;
      sat_ff <= sat_in;
   end

   assign result   = res_ff;
   assign rsp.done = done_ff;
   assign rsp.sat  = sat_ff;

endmodule

[src/spline_fit_normal_equation_accumulator.sv]
// Top level of the spline fit normal equation accumulator.
// Uses sfn_pkg, sfn_ram (knot, power sum and offset stores) and sfn_mul.
//
// One command beat is taken when start is high and busy is low; each command gives one
// result beat on rsp_valid for one cycle, which the receiver cannot stall. Knot loads,
// rejected reads and unknown operations answer on the next cycle; reads answer from the
// S_RDW state, after one registered RAM read. An add point runs S knot search steps (one
// RAM read and compare each), then, with P the effective order, 6*P+6 passes through the
// shared multiplier plus one read-modify-write per power sum. A clear zeroes one offset
// store entry per cycle, and a power sum entry alongside while any are left, over all
// (MAX_KNOTS-1)*2*(MAX_ORDER+1) entries, 372 by default; the same clearing pass runs after
// reset with busy high. Configuration writes are taken at any time.
module spline_fit_normal_equation_accumulator #(
   parameter int MAX_KNOTS = sfn_pkg::MAX_KNOTS_DEF,
   parameter int MAX_ORDER = sfn_pkg::MAX_ORDER_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_operation,
   input  logic [4:0]         req_item_index,
   input  logic signed [31:0] req_position,
   input  logic signed [31:0] req_ref_x,
   input  logic signed [31:0] req_ref_y,
   input  logic [3:0]         req_term_index,
   input  logic               req_axis,
   output logic               rsp_valid,
   output logic signed [63:0] rsp_read_value,
   output logic [4:0]         rsp_segment,
   output logic [1:0]         rsp_status,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_write_data
);
   import sfn_pkg::*;

   localparam int NPOW      = 2 * MAX_ORDER + 1;
   localparam int NCOEF     = MAX_ORDER + 1;
   localparam int PS_DEPTH  = (MAX_KNOTS - 1) * NPOW;
   localparam int OF_DEPTH  = (MAX_KNOTS - 1) * 2 * NCOEF;
   localparam int CLR_DEPTH = (PS_DEPTH > OF_DEPTH) ? PS_DEPTH : OF_DEPTH;
   localparam int KA        = $clog2(MAX_KNOTS);
   localparam int KW        = $clog2(MAX_KNOTS + 1);
   localparam int PSA       = $clog2(PS_DEPTH);
   localparam int OFA       = $clog2(OF_DEPTH);
   localparam int CLA       = $clog2(CLR_DEPTH);

   typedef enum logic [11:0] {
      S_CLR   = 12'b0000_0000_0001,
      S_IDLE  = 12'b0000_0000_0010,
      S_KRD   = 12'b0000_0000_0100,
      S_KCMP  = 12'b0000_0000_1000,
      S_KSEL  = 12'b0000_0001_0000,
      S_BASE  = 12'b0000_0010_0000,
      S_ISSUE = 12'b0000_0100_0000,
      S_MUL   = 12'b0000_1000_0000,
      S_PADD  = 12'b0001_0000_0000,
      S_OWX   = 12'b0010_0000_0000,
      S_OWY   = 12'b0100_0000_0000,
      S_RDW   = 12'b1000_0000_0000
   } state_type;

   typedef enum logic [2:0] {
      M_INC, M_PW, M_CX, M_CY, M_NX, M_NY
   } mop_type;

   state_type state_ff, state_in;
   mop_type   mop_ff, mop_in;

   logic [5:0]  csr_knots_ff;
   logic [2:0]  csr_order_ff;
   logic [31:0] csr_weight_ff;
   logic [KW-1:0] k_eff;
   logic [2:0]    p_eff;

   logic [2:0]         op_ff, op_in;
   logic signed [31:0] pos_ff, pos_in, rx_ff, rx_in, ry_ff, ry_in;
   logic [KW-1:0]      j_ff, j_in, j_min;
   logic [KA-1:0]      seg_ff, seg_in;
   logic signed [32:0] r_ff, r_in;
   logic signed [63:0] pw_ff, pw_in, inc_ff, inc_in, cx_ff, cx_in, cy_ff, cy_in;
   logic [3:0]         n_ff, n_in;
   logic [PSA-1:0]     ps_addr_ff, ps_addr_in;
   logic [OFA-1:0]     of_addr_ff, of_addr_in;
   logic               sat_ff, sat_in;
   logic [CLA-1:0]     clr_cnt_ff, clr_cnt_in;
   logic               clr_rsp_ff, clr_rsp_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [63:0] rsp_value_ff, rsp_value_in;
   logic [4:0]         rsp_seg_ff, rsp_seg_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;

   logic               knot_we;
   logic [KA-1:0]      knot_waddr, knot_raddr;
   logic [31:0]        knot_wdata, knot_rdata;
   logic               ps_we;
   logic [PSA-1:0]     ps_waddr, ps_raddr;
   logic [63:0]        ps_wdata, ps_rdata;
   logic               of_we;
   logic [OFA-1:0]     of_waddr, of_raddr;
   logic [63:0]        of_wdata, of_rdata;

   logic               mul_start;
   logic signed [63:0] mul_a, mul_b, mul_res;
   mul_rsp_type        mul_rsp;

   logic [64:0]        sum65;
   logic signed [63:0] sum_sat;
   logic               sum_ovf;
   logic               sum_ok, off_ok;

   always_comb begin
      if (csr_knots_ff < 6'd2) begin
         k_eff = KW'(2);
      end else if (32'(csr_knots_ff) > MAX_KNOTS) begin
         k_eff = KW'(MAX_KNOTS);
      end else begin
         k_eff = KW'(csr_knots_ff);
      end
      if (csr_order_ff < 3'd1) begin
         p_eff = 3'd1;
      end else if (32'(csr_order_ff) > MAX_ORDER) begin
         p_eff = 3'(MAX_ORDER);
      end else begin
         p_eff = csr_order_ff;
      end
   end

   always_comb begin
      sum65   = {ps_rdata[63], ps_rdata} + {inc_ff[63], inc_ff};
      sum_ovf = sum65[64] != sum65[63];
      sum_sat = sum_ovf ? (sum65[64] ? S64_MIN : S64_MAX) : sum65[63:0];
      sum_ok  = (32'(req_item_index) < 32'(k_eff) - 32'd1)
                && (32'(req_term_index) <= 2 * 32'(p_eff));
      off_ok  = (32'(req_item_index) < 32'(k_eff) - 32'd1)
                && (32'(req_term_index) <= 32'(p_eff));
      j_min   = (j_ff < k_eff - KW'(1)) ? j_ff : (k_eff - KW'(1));
   end

   always_comb begin
      case (mop_ff)
         M_INC: begin
            mul_a = 64'(csr_weight_ff);
            mul_b = pw_ff;
         end
         M_PW: begin
            mul_a = pw_ff;
            mul_b = 64'(r_ff);
         end
         M_CX: begin
            mul_a = {16'd0, csr_weight_ff, 16'd0};
            mul_b = 64'sd0 - 64'(rx_ff);
         end
         M_CY: begin
            mul_a = {16'd0, csr_weight_ff, 16'd0};
            mul_b = 64'sd0 - 64'(ry_ff);
         end
         M_NX: begin
            mul_a = cx_ff;
            mul_b = 64'(r_ff);
         end
         default: begin
            mul_a = cy_ff;
            mul_b = 64'(r_ff);
         end
      endcase
      mul_start = state_ff == S_ISSUE;
   end

   always_comb begin
      state_in      = state_ff;
      mop_in        = mop_ff;
      op_in         = op_ff;
      pos_in        = pos_ff;
      rx_in         = rx_ff;
      ry_in         = ry_ff;
      j_in          = j_ff;
      seg_in        = seg_ff;
      r_in          = r_ff;
      pw_in         = pw_ff;
      inc_in        = inc_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      n_in          = n_ff;
      ps_addr_in    = ps_addr_ff;
      of_addr_in    = of_addr_ff;
      sat_in        = sat_ff;
      clr_cnt_in    = clr_cnt_ff;
      clr_rsp_in    = clr_rsp_ff;
      rsp_valid_in  = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_seg_in    = rsp_seg_ff;
      rsp_status_in = rsp_status_ff;

      knot_we    = 1'b0;
      knot_waddr = KA'(req_item_index);
      knot_wdata = req_position;
      knot_raddr = j_ff[KA-1:0];
      ps_we      = 1'b0;
      ps_waddr   = ps_addr_ff;
      ps_wdata   = sum_sat;
      ps_raddr   = ps_addr_ff;
      of_we      = 1'b0;
      of_waddr   = of_addr_ff;
      of_wdata   = cx_ff;
      of_raddr   = of_addr_ff;

      case (state_ff)
         S_CLR: begin
            ps_we    = 32'(clr_cnt_ff) < PS_DEPTH;
            ps_waddr = clr_cnt_ff[PSA-1:0];
            ps_wdata = 64'd0;
            of_we    = 32'(clr_cnt_ff) < OF_DEPTH;
            of_waddr = clr_cnt_ff[OFA-1:0];
            of_wdata = 64'd0;
            if (clr_cnt_ff == CLA'(CLR_DEPTH - 1)) begin
               state_in = S_IDLE;
               if (clr_rsp_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_value_in  = 64'sd0;
                  rsp_seg_in    = 5'd0;
                  rsp_status_in = ST_OK;
               end
            end else begin
               clr_cnt_in = clr_cnt_ff + CLA'(1);
            end
         end
         S_IDLE: begin
            ps_raddr = PSA'(32'(req_item_index) * NPOW + 32'(req_term_index));
            of_raddr = OFA'((32'(req_item_index) * 2 + 32'(req_axis)) * NCOEF
                            + 32'(req_term_index));
            if (start) begin
               op_in         = req_operation;
               pos_in        = req_position;
               rx_in         = req_ref_x;
               ry_in         = req_ref_y;
               sat_in        = 1'b0;
               rsp_value_in  = 64'sd0;
               rsp_seg_in    = 5'd0;
               rsp_status_in = ST_OK;
               case (req_operation)
                  OP_LOAD: begin
                     rsp_valid_in = 1'b1;
                     if (32'(req_item_index) < MAX_KNOTS) begin
                        knot_we = 1'b1;
                     end else begin
                        rsp_status_in = ST_RANGE;
                     end
                  end
                  OP_ADD: begin
                     j_in     = KW'(1);
                     state_in = S_KRD;
                  end
                  OP_RD_SUM: begin
                     if (sum_ok) begin
                        state_in = S_RDW;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_RANGE;
                     end
                  end
                  OP_RD_OFF: begin
                     if (off_ok) begin
                        state_in = S_RDW;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_RANGE;
                     end
                  end
                  OP_CLEAR: begin
                     clr_cnt_in = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = S_CLR;
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_RANGE;
                  end
               endcase
            end
         end
         S_KRD: begin
            state_in = S_KCMP;
         end
         S_KCMP: begin
            if ($signed(knot_rdata) <= pos_ff) begin
               j_in     = j_ff + KW'(1);
               state_in = ((j_ff + KW'(1)) < k_eff) ? S_KRD : S_KSEL;
            end else begin
               state_in = S_KSEL;
            end
         end
         S_KSEL: begin
            seg_in     = KA'(j_min - KW'(1));
            knot_raddr = KA'(j_min - KW'(1));
            state_in   = S_BASE;
         end
         S_BASE: begin
            r_in       = $signed({pos_ff[31], pos_ff}) - $signed({knot_rdata[31], knot_rdata});
            ps_addr_in = PSA'(32'(seg_ff) * NPOW);
            of_addr_in = OFA'(32'(seg_ff) * 2 * NCOEF);
            n_in       = 4'd0;
            pw_in      = Q32_ONE;
            mop_in     = M_INC;
            state_in   = S_ISSUE;
         end
         S_ISSUE: begin
            state_in = S_MUL;
         end
         S_MUL: begin
            if (mul_rsp.done) begin
               sat_in = sat_ff | mul_rsp.sat;
               case (mop_ff)
                  M_INC: begin
                     inc_in   = mul_res;
                     state_in = S_PADD;
                  end
                  M_PW: begin
                     pw_in    = mul_res;
                     state_in = S_ISSUE;
                     if (n_ff == {p_eff, 1'b0}) begin
                        n_in   = 4'd0;
                        mop_in = M_CX;
                     end else begin
                        n_in       = n_ff + 4'd1;
                        ps_addr_in = ps_addr_ff + PSA'(1);
                        mop_in     = M_INC;
                     end
                  end
                  M_CX: begin
                     cx_in    = mul_res;
                     mop_in   = M_CY;
                     state_in = S_ISSUE;
                  end
                  M_CY: begin
                     cy_in    = mul_res;
                     state_in = S_OWX;
                  end
                  M_NX: begin
                     cx_in    = mul_res;
                     mop_in   = M_NY;
                     state_in = S_ISSUE;
                  end
                  default: begin
                     cy_in = mul_res;
                     if (n_ff == {1'b0, p_eff}) begin
                        rsp_valid_in  = 1'b1;
                        rsp_value_in  = 64'sd0;
                        rsp_seg_in    = 5'(seg_ff);
                        rsp_status_in = (sat_ff | mul_rsp.sat) ? ST_SAT : ST_OK;
                        state_in      = S_IDLE;
                     end else begin
                        n_in       = n_ff + 4'd1;
                        of_addr_in = of_addr_ff + OFA'(1);
                        state_in   = S_OWX;
                     end
                  end
               endcase
            end
         end
         S_PADD: begin
            ps_we    = 1'b1;
            sat_in   = sat_ff | sum_ovf;
            mop_in   = M_PW;
            state_in = S_ISSUE;
         end
         S_OWX: begin
            of_we    = 1'b1;
            state_in = S_OWY;
         end
         S_OWY: begin
            of_we    = 1'b1;
            of_waddr = OFA'(32'(of_addr_ff) + NCOEF);
            of_wdata = cy_ff;
            mop_in   = M_NX;
            state_in = S_ISSUE;
         end
         S_RDW: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = (op_ff == OP_RD_SUM) ? ps_rdata : of_rdata;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLR;
         clr_cnt_ff    <= '0;
         clr_rsp_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         csr_knots_ff  <= 6'd2;
         csr_order_ff  <= 3'd5;
         csr_weight_ff <= 32'd65536;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_KNOTS:  csr_knots_ff  <= csr_write_data[5:0];
               CSR_ORDER:  csr_order_ff  <= csr_write_data[2:0];
               CSR_WEIGHT: csr_weight_ff <= csr_write_data;
               default: ;
            endcase
         end
      end
      mop_ff        <= mop_in;
      op_ff         <= op_in;
      pos_ff        <= pos_in;
      rx_ff         <= rx_in;
      ry_ff         <= ry_in;
      j_ff          <= j_in;
      seg_ff        <= seg_in;
      r_ff          <= r_in;
      pw_ff         <= pw_in;
      inc_ff        <= inc_in;
      cx_ff         <= cx_in;
      cy_ff         <= cy_in;
      n_ff          <= n_in;
      ps_addr_ff    <= ps_addr_in;
      of_addr_ff    <= of_addr_in;
      sat_ff        <= sat_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_seg_ff    <= rsp_seg_in;
      rsp_status_ff <= rsp_status_in;
   end

   sfn_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_knot_ram (
      .clock (clock),
      .we    (knot_we),
      .waddr (knot_waddr),
      .wdata (knot_wdata),
      .raddr (knot_raddr),
      .rdata (knot_rdata)
   );

   sfn_ram #(.WIDTH(64), .DEPTH(PS_DEPTH)) u_sum_ram (
      .clock (clock),
      .we    (ps_we),
      .waddr (ps_waddr),
      .wdata (ps_wdata),
      .raddr (ps_raddr),
      .rdata (ps_rdata)
   );

   sfn_ram #(.WIDTH(64), .DEPTH(OF_DEPTH)) u_off_ram (
      .clock (clock),
      .we    (of_we),
      .waddr (of_waddr),
      .wdata (of_wdata),
      .raddr (of_raddr),
      .rdata (of_rdata)
   );

   sfn_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .result (mul_res),
      .rsp    (mul_rsp)
   );

   assign busy           = state_ff != S_IDLE;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_segment    = rsp_seg_ff;
   assign rsp_status     = rsp_status_ff;

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted beat neither busy nor answered");

   a_err_value_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_read_value == 64'sd0))
      else $error("nonzero value with error status");

   a_mul_done_state: assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> (state_ff == S_MUL))
      else $error("multiplier result outside wait state");

   a_seg_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_segment != 5'd0) |-> (rsp_status != ST_RANGE))
      else $error("segment reported with range error");

endmodule

[tb/sv/spline_fit_normal_equation_accumulator_tb.sv]
// Self-checking testbench for spline_fit_normal_equation_accumulator.
// Drives command beats with random gaps, predicts each result beat in-line or takes a
// hand-written one, and compares it with the DUT's output. Depends on sfn_pkg and the DUT only.
module spline_fit_normal_equation_accumulator_tb;
   import sfn_pkg::*;

   localparam int NKNOT = 32;
   localparam int NPOW  = 11;
   localparam int NCOEF = 6;
   localparam int NRAND = 1540;
   localparam logic [2:0] OP_BAD5 = 3'd5;
   localparam logic [2:0] OP_BAD6 = 3'd6;
   localparam logic [2:0] OP_BAD7 = 3'd7;

   typedef struct {
      logic signed [63:0] value;
      logic [4:0]         seg;
      logic [1:0]         status;
   } rsp_beat_type;

   typedef struct {
      logic [2:0]         op;
      logic [4:0]         idx;
      logic signed [31:0] pos;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic [3:0]         term;
      logic               axis;
      bit                 typed;
      rsp_beat_type       beat;
   } cmd_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [2:0]         req_operation = '0;
   logic [4:0]         req_item_index = '0;
   logic signed [31:0] req_position = '0;
   logic signed [31:0] req_ref_x = '0;
   logic signed [31:0] req_ref_y = '0;
   logic [3:0]         req_term_index = '0;
   logic               req_axis = 1'b0;
   logic               rsp_valid;
   logic signed [63:0] rsp_read_value;
   logic [4:0]         rsp_segment;
   logic [1:0]         rsp_status;
   logic               csr_write_enable = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [31:0]        csr_write_data = '0;

   logic [31:0]        knot_mem [NKNOT];
   logic signed [63:0] power_sum_mem [(NKNOT-1)*NPOW];
   logic signed [63:0] offset_mem [(NKNOT-1)*2*NCOEF];
   logic [5:0]         knots_reg;
   logic [2:0]         order_reg;
   logic [31:0]        weight_reg;
   bit                 sat_seen;
   rsp_beat_type       expected_beats [$];
   int                 errors = 0;

   spline_fit_normal_equation_accumulator DUT (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #40_000_000;
      $display("spline_fit_normal_equation_accumulator_tb failed");
      $finish;
   end

   function automatic logic signed [63:0] mul_q16(logic signed [63:0] a, logic signed [63:0] b);
      logic signed [127:0] prod;
      prod = (128'(a) * 128'(b)) >>> 16;
      if (prod[127:63] != {65{prod[63]}}) begin
         sat_seen = 1'b1;
         return prod[127] ? S64_MIN : S64_MAX;
      end
      return prod[63:0];
   endfunction

   function automatic logic signed [63:0] add_s64(logic signed [63:0] a, logic signed [63:0] b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s[64] != s[63]) begin
         sat_seen = 1'b1;
         return s[64] ? S64_MIN : S64_MAX;
      end
      return s[63:0];
   endfunction

   function automatic rsp_beat_type predict_beat(cmd_row_type c);
      rsp_beat_type b;
      int k, p, j, seg;
      logic signed [63:0] r, pw, w, cx, cy, inc;
      b = '{value: 0, seg: 0, status: ST_OK};
      k = (knots_reg < 2) ? 2 : (knots_reg > NKNOT) ? NKNOT : knots_reg;
      p = (order_reg < 1) ? 1 : (order_reg > 5) ? 5 : order_reg;
      case (c.op)
         OP_LOAD: knot_mem[c.idx] = c.pos;
         OP_ADD: begin
            sat_seen = 1'b0;
            j = 1;
            while (j < k && $signed(knot_mem[j]) <= c.pos) j++;
            seg = ((j < k - 1) ? j : k - 1) - 1;
            r = 64'(c.pos) - 64'($signed(knot_mem[seg]));
            pw = Q32_ONE;
            w = {32'd0, weight_reg};
            for (int n = 0; n <= 2 * p; n++) begin
               inc = mul_q16(w, pw);
               power_sum_mem[seg*NPOW+n] = add_s64(power_sum_mem[seg*NPOW+n], inc);
               pw = mul_q16(pw, r);
            end
            cx = -(w * 64'(c.x));
            cy = -(w * 64'(c.y));
            for (int n = 0; n <= p; n++) begin
               offset_mem[(seg*2)*NCOEF+n] = cx;
               offset_mem[(seg*2+1)*NCOEF+n] = cy;
               cx = mul_q16(cx, r);
               cy = mul_q16(cy, r);
            end
            b.seg = 5'(seg);
            b.status = sat_seen ? ST_SAT : ST_OK;
         end
         OP_RD_SUM: begin
            if (c.idx < k - 1 && c.term <= 2 * p) b.value = power_sum_mem[c.idx*NPOW+c.term];
            else b.status = ST_RANGE;
         end
         OP_RD_OFF: begin
            if (c.idx < k - 1 && c.term <= p)
               b.value = offset_mem[(c.idx*2+c.axis)*NCOEF+c.term];
            else b.status = ST_RANGE;
         end
         OP_CLEAR: begin
            foreach (power_sum_mem[i]) power_sum_mem[i] = 0;
            foreach (offset_mem[i]) offset_mem[i] = 0;
         end
         default: b.status = ST_RANGE;
      endcase
      return b;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_beats.size() == 0) begin
            report_mismatch("unexpected beat", rsp_read_value, 0);
         end else begin
            if (rsp_read_value !== expected_beats[0].value)
               report_mismatch("read_value", rsp_read_value, expected_beats[0].value);
            if (rsp_segment !== expected_beats[0].seg)
               report_mismatch("segment", rsp_segment, expected_beats[0].seg);
            if (rsp_status !== expected_beats[0].status)
               report_mismatch("status", rsp_status, expected_beats[0].status);
            void'(expected_beats.pop_front());
         end
      end
   end

   task automatic send_cmd(cmd_row_type c, int gap);
      rsp_beat_type b;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_operation <= c.op;
      req_item_index <= c.idx;
      req_position <= c.pos;
      req_ref_x <= c.x;
      req_ref_y <= c.y;
      req_term_index <= c.term;
      req_axis <= c.axis;
      do @(posedge clock); while (busy);
      b = predict_beat(c);
      expected_beats.push_back(c.typed ? c.beat : b);
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      do @(posedge clock); while (expected_beats.size() != 0);
      repeat (20) @(posedge clock);
   endtask

   // leaves the write enable high; the caller drops it after the last write
   task automatic write_csr(logic [1:0] index, logic [31:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      @(posedge clock);
      case (index)
         CSR_KNOTS: knots_reg = data[5:0];
         CSR_ORDER: order_reg = data[2:0];
         default:   weight_reg = data;
      endcase
   endtask

   function automatic cmd_row_type mk(logic [2:0] op, logic [4:0] idx, logic [31:0] pos,
                                      logic [31:0] x, logic [31:0] y, logic [3:0] term,
                                      logic axis);
      cmd_row_type c;
      c = '{op: op, idx: idx, pos: pos, x: x, y: y, term: term, axis: axis,
            typed: 0, beat: '{value: 0, seg: 0, status: ST_OK}};
      return c;
   endfunction

   function automatic cmd_row_type mk_typed(cmd_row_type c, logic signed [63:0] v,
                                            logic [1:0] st);
      c.typed = 1;
      c.beat = '{value: v, seg: 0, status: st};
      return c;
   endfunction

   // load every knot, ascending unless scrambled
   task automatic load_knots(bit scramble);
      logic signed [31:0] kv;
      kv = -32'sd1073741824 + $signed($urandom_range(0, 1 << 28));
      for (int i = 0; i < NKNOT; i++) begin
         send_cmd(mk(OP_LOAD, 5'(i), scramble ? $urandom : kv, $urandom, $urandom,
                     4'($urandom), 1'($urandom)),
                  $urandom_range(0, 3));
         kv = kv + $signed($urandom_range(1, 1 << 25));
      end
   endtask

   function automatic cmd_row_type random_cmd();
      cmd_row_type c;
      int sel, hi;
      c = mk(OP_ADD, 5'($urandom), $urandom, $urandom, $urandom, 4'($urandom), 1'($urandom));
      sel = $urandom_range(0, 99);
      hi = (knots_reg < 2) ? 1 : (knots_reg > NKNOT) ? NKNOT - 1 : knots_reg - 1;
      if (sel < 40) begin
         if ($urandom_range(0, 3) != 0)
            c.pos = $signed(knot_mem[0]) +
                    $signed($urandom_range(0, $signed(knot_mem[hi]) - $signed(knot_mem[0])))
                    - 32'sd4096 + $signed($urandom_range(0, 8192));
      end else if (sel < 60) begin
         c.op = OP_RD_SUM;
      end else if (sel < 85) begin
         c.op = OP_RD_OFF;
      end else if (sel < 92) begin
         c.op = OP_LOAD;
      end else if (sel < 93) begin
         c.op = OP_CLEAR;
      end else begin
         c.op = 3'($urandom_range(OP_BAD5, OP_BAD7));
      end
      if (c.op inside {OP_RD_SUM, OP_RD_OFF} && $urandom_range(0, 3) != 0) begin
         c.idx = 5'($urandom_range(0, hi - 1));
         c.term = 4'($urandom_range(0, 10));
      end
      return c;
   endfunction

   initial begin
      cmd_row_type dir_rows [$];
      int settings [7][3];
      int n_sent;
      settings = '{'{2, 5, 65536}, '{32, 5, 32'hFFFF_FFFF}, '{32, 1, 0}, '{0, 7, 1},
                   '{63, 0, 32'h0001_8000}, '{8, 3, 32'h0000_4000}, '{17, 2, 65536}};
      foreach (knot_mem[i]) knot_mem[i] = 0;
      foreach (power_sum_mem[i]) power_sum_mem[i] = 0;
      foreach (offset_mem[i]) offset_mem[i] = 0;
      knots_reg = 2;
      order_reg = 5;
      weight_reg = 65536;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      dir_rows = '{
         mk_typed(mk(OP_RD_SUM, 0, 0, 0, 0, 0, 0), 0, ST_OK),
         mk_typed(mk(OP_RD_SUM, 0, 0, 0, 0, 10, 0), 0, ST_OK),
         mk_typed(mk(OP_RD_SUM, 0, 0, 0, 0, 11, 0), 0, ST_RANGE),
         mk_typed(mk(OP_RD_OFF, 0, 0, 0, 0, 6, 1), 0, ST_RANGE),
         mk_typed(mk(OP_RD_OFF, 1, 0, 0, 0, 0, 0), 0, ST_RANGE),
         mk_typed(mk(OP_RD_SUM, 31, 0, 0, 0, 15, 0), 0, ST_RANGE),
         mk_typed(mk(OP_BAD5, 0, 0, 0, 0, 0, 0), 0, ST_RANGE),
         mk_typed(mk(OP_BAD6, 0, 0, 0, 0, 0, 0), 0, ST_RANGE),
         mk_typed(mk(OP_BAD7, 31, '1, '1, '1, '1, 1), 0, ST_RANGE),
         mk(OP_LOAD, 0, 32'sh0000_0000, 0, 0, 0, 0),
         mk(OP_LOAD, 1, 32'sh0001_0000, 0, 0, 0, 0),
         mk(OP_ADD, 0, 32'sh0000_8000, 32'sh0001_0000, 32'shFFFF_0000, 0, 0),
         mk(OP_ADD, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0),
         mk(OP_ADD, 0, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0),
         mk(OP_RD_SUM, 0, 0, 0, 0, 0, 0),
         mk(OP_RD_SUM, 0, 0, 0, 0, 10, 0),
         mk(OP_RD_OFF, 0, 0, 0, 0, 0, 0),
         mk(OP_RD_OFF, 0, 0, 0, 0, 5, 1),
         mk(OP_CLEAR, 0, 0, 0, 0, 0, 0),
         mk_typed(mk(OP_RD_SUM, 0, 0, 0, 0, 3, 0), 0, ST_OK),
         mk_typed(mk(OP_RD_OFF, 0, 0, 0, 0, 2, 1), 0, ST_OK)
      };
      foreach (dir_rows[i]) send_cmd(dir_rows[i], $urandom_range(0, 2));
      load_knots(0);

      n_sent = 0;
      for (int ph = 0; ph < 7; ph++) begin
         wait_idle();
         write_csr(CSR_KNOTS, settings[ph][0]);
         write_csr(CSR_ORDER, settings[ph][1]);
         write_csr(CSR_WEIGHT, settings[ph][2]);
         csr_write_enable <= 1'b0;
         load_knots(ph == 5);
         for (int i = 0; i < NRAND / 7; i++) begin
            if (i == 100) wait_idle();
            send_cmd(random_cmd(), ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18));
            n_sent++;
         end
      end
      wait_idle();
      repeat (400) @(posedge clock);
      if (errors == 0 && expected_beats.size() == 0)
         $display("spline_fit_normal_equation_accumulator_tb passed");
      else
         $display("spline_fit_normal_equation_accumulator_tb failed");
      $finish;
   end
endmodule
